// File: design/grid_tetrahedra_index_generator_defines.svh
// Assertion macros shared by the grid tetrahedra index generator RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef GRID_TETRAHEDRA_INDEX_GENERATOR_DEFINES_SVH
`define GRID_TETRAHEDRA_INDEX_GENERATOR_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define GTIG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define GTIG_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: design/gtig_pkg.sv
// Package for the grid tetrahedra index generator: widths, defaults and the
// corner offset table. No dependencies.
package gtig_pkg;

  localparam int X_BITS_DEF = 6;
  localparam int Y_BITS_DEF = 6;
  localparam int Z_BITS_DEF = 6;

  localparam int CELL_INDICES = 24;
  localparam int CNT_W        = 5;
  localparam int TETRA_W      = 3;
  localparam int CORNER_W     = 2;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CELL_INDICES - 1);

  // Corner offset per result: bit 0 = +x, bit 1 = +y, bit 2 = +z.
  function automatic logic [2:0] corner_offset(input logic [CNT_W-1:0] k);
    logic [2:0] off;
    unique case (k)
      5'd0:    off = 3'd1;
      5'd1:    off = 3'd0;
      5'd2:    off = 3'd3;
      5'd3:    off = 3'd7;
      5'd4:    off = 3'd7;
      5'd5:    off = 3'd0;
      5'd6:    off = 3'd3;
      5'd7:    off = 3'd2;
      5'd8:    off = 3'd2;
      5'd9:    off = 3'd0;
      5'd10:   off = 3'd6;
      5'd11:   off = 3'd7;
      5'd12:   off = 3'd0;
      5'd13:   off = 3'd4;
      5'd14:   off = 3'd6;
      5'd15:   off = 3'd7;
      5'd16:   off = 3'd4;
      5'd17:   off = 3'd0;
      5'd18:   off = 3'd5;
      5'd19:   off = 3'd7;
      5'd20:   off = 3'd0;
      5'd21:   off = 3'd1;
      5'd22:   off = 3'd5;
      5'd23:   off = 3'd7;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

// File: design/grid_tetrahedra_index_generator.sv
// Grid tetrahedra index generator: point index in, 24 corner indices out.
// Depends on gtig_pkg and grid_tetrahedra_index_generator_defines.svh.
//
// Each item is a grid point index; a point that is the low corner of a cube
// cell yields 24 results (six tetrahedra of four corners each, tetrahedron 0
// first), the 24th flagged by last. Points on the far face of any axis yield
// nothing. The point passes an input register, a coordinate decode stage
// (swizzled 2x2x2 blocks or plain raster, per swizzle_enable), the corner
// sequencer and the output register, in that order. The corner sequencer
// issues one result per cycle while the output register is not held by
// vertex_stall, so a cell occupies it for all 24 results before the next;
// far-face points leave the decode stage without waiting for it, and the
// next cell is loaded as the previous one issues its last result.
// swizzle_enable resets to 1 and is written through cfg_we / cfg_wdata.
`include "grid_tetrahedra_index_generator_defines.svh"

module grid_tetrahedra_index_generator #(
  parameter int X_BITS = gtig_pkg::X_BITS_DEF,
  parameter int Y_BITS = gtig_pkg::Y_BITS_DEF,
  parameter int Z_BITS = gtig_pkg::Z_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata,
  input  logic                                  point_valid,
  output logic                                  point_stall,
  input  logic [X_BITS+Y_BITS+Z_BITS-1:0]       point_index,
  output logic                                  vertex_valid,
  input  logic                                  vertex_stall,
  output logic [X_BITS+Y_BITS+Z_BITS-1:0]       vertex_index,
  output logic [gtig_pkg::TETRA_W-1:0]          tetra_number,
  output logic [gtig_pkg::CORNER_W-1:0]         corner_number,
  output logic                                  last
);
  import gtig_pkg::*;

  localparam int TOTAL_BITS = X_BITS + Y_BITS + Z_BITS;

  logic swizzle_enable;

  // stage 1: input register
  logic                  v1;
  logic [TOTAL_BITS-1:0] idx1;

  // stage 2: decoded coordinates
  logic              v2;
  logic [X_BITS-1:0] x2;
  logic [Y_BITS-1:0] y2;
  logic [Z_BITS-1:0] z2;

  // stage 3: corner sequencer
  logic              v3;
  logic [X_BITS-1:0] x3;
  logic [Y_BITS-1:0] y3;
  logic [Z_BITS-1:0] z3;
  logic [CNT_W-1:0]  cnt;

  logic [X_BITS-1:0] x_dec;
  logic [Y_BITS-1:0] y_dec;
  logic [Z_BITS-1:0] z_dec;

  logic              emit;
  logic              done3;
  logic              far2;
  logic              take2;
  logic              adv2;
  logic [2:0]        off;
  logic [X_BITS-1:0] xs;
  logic [Y_BITS-1:0] ys;
  logic [Z_BITS-1:0] zs;
  logic              last_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      swizzle_enable <= 1'b1;
    end else if (cfg_we) begin
      swizzle_enable <= cfg_wdata;
    end
  end

  // Coordinate decode. Swizzled: bits 0..2 are the low bits of x, y, z, the
  // rest holds the upper bits in raster order.
  always_comb begin
    x_dec = idx1[X_BITS-1:0];
    y_dec = idx1[X_BITS +: Y_BITS];
    z_dec = idx1[X_BITS+Y_BITS +: Z_BITS];
    if (swizzle_enable) begin
      x_dec[0] = idx1[0];
      y_dec[0] = idx1[1];
      z_dec[0] = idx1[2];
      for (int i = 1; i < X_BITS; i++) begin
        x_dec[i] = idx1[i+2];
      end
      for (int i = 1; i < Y_BITS; i++) begin
        y_dec[i] = idx1[X_BITS+1+i];
      end
      for (int i = 1; i < Z_BITS; i++) begin
        z_dec[i] = idx1[X_BITS+Y_BITS+i];
      end
    end
  end

  assign emit  = v3 && (!vertex_valid || !vertex_stall);
  assign done3 = emit && (cnt == LAST_CNT);
  assign far2  = (x2 == '1) || (y2 == '1) || (z2 == '1);
  // far-face points are dropped here without reaching the sequencer
  assign take2 = v2 && (far2 || !v3 || done3);
  assign adv2  = !v2 || take2;

  assign point_stall = v1 && !adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!point_stall) begin
      v1 <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!point_stall) begin
      idx1 <= point_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      x2 <= x_dec;
      y2 <= y_dec;
      z2 <= z_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3  <= 1'b0;
      cnt <= '0;
    end else begin
      priority if (take2 && !far2) begin
        v3  <= 1'b1;
        cnt <= '0;
      end else if (done3) begin
        v3  <= 1'b0;
        cnt <= '0;
      end else begin
        if (emit) begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take2 && !far2) begin
      x3 <= x2;
      y3 <= y2;
      z3 <= z2;
    end
  end

  // Coordinates never sit at their maximum here, so the +1 cannot wrap.
  assign off = corner_offset(cnt);
  assign xs  = x3 + X_BITS'(off[0]);
  assign ys  = y3 + Y_BITS'(off[1]);
  assign zs  = z3 + Z_BITS'(off[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (emit) begin
      vertex_valid <= 1'b1;
    end else if (!vertex_stall) begin
      vertex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      vertex_index  <= {zs, ys, xs};
      tetra_number  <= cnt[CNT_W-1:2];
      corner_number <= cnt[1:0];
      last          <= (cnt == LAST_CNT);
    end
  end

  // tetrahedron and corner together are the result count
  assign last_slot = ({tetra_number, corner_number} == LAST_CNT);

  `GTIG_ASSERT(a_last_on_final_corner, vertex_valid |-> (last == last_slot), "last misplaced")
  `GTIG_ASSERT(a_cnt_restarts, done3 |=> (cnt == '0), "corner counter did not restart")
  `GTIG_ASSERT_NEVER(a_no_far_cell, v3 && (&x3 || &y3 || &z3), "far-face point in sequencer")
  `GTIG_ASSERT(a_cell_held, (vertex_valid && !last) |-> v3, "cell left before last corner")

endmodule
